[hdl/mhp_pkg.sv]
`timescale 1ns / 1ps
package mhp_pkg;

  localparam int MAX_COINS   = 1024;
  localparam int FRAC_BITS   = 24;
  localparam int PROB_W      = 17;
  localparam int PROB_FRAC   = 16;
  localparam int DIST_W      = FRAC_BITS + 1;
  localparam int NUM_CELLS   = MAX_COINS + 1;
  localparam int COUNT_W     = $clog2(MAX_COINS + 1);
  localparam int OUT_COUNT_W = 11;
  localparam int MIX_W       = DIST_W + 1 + PROB_W + 1;

  localparam logic [PROB_W-1:0]       PROB_ONE = PROB_W'(1) << PROB_FRAC;
  localparam logic [DIST_W-1:0]       DIST_ONE = DIST_W'(1) << FRAC_BITS;
  localparam logic [COUNT_W-1:0]      COUNT_MAX = COUNT_W'(MAX_COINS);
  localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(1) << (PROB_FRAC - 1);

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UPDATE,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PROB_W-1:0] prob;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

[hdl/mhp_if.sv]
`timescale 1ns / 1ps
interface mhp_in_if;
  logic                        valid;
  logic                        ready;
  logic [mhp_pkg::PROB_W-1:0]  coin_probability;
  logic                        last_coin;

  modport source (output valid, coin_probability, last_coin, input ready);
  modport sink   (input valid, coin_probability, last_coin, output ready);
endinterface

interface mhp_out_if;
  logic                             valid;
  logic                             ready;
  logic [mhp_pkg::DIST_W-1:0]       tail_probability;
  logic [mhp_pkg::OUT_COUNT_W-1:0]  coins_seen;
  logic                             too_many_coins;

  modport source (output valid, tail_probability, coins_seen, too_many_coins, input ready);
  modport sink   (input valid, tail_probability, coins_seen, too_many_coins, output ready);
endinterface

[hdl/majority_heads_probability_top.sv]
`timescale 1ns / 1ps
// majority heads probability
// in_coin carries one coin per beat: its head probability in Q1.16 (values
// above 1.0 count as 1.0) and a flag for the last coin of a set. out_result
// carries one beat per set: the probability of at least ceil(n/2) heads in
// Q1.24, the coin count n and a flag for coins dropped beyond capacity.
// the head-count distribution lives in a row of cells, one per count; each
// cell updates its entry from its lower neighbor, so a coin that is not last
// is folded in at once and the next coin may follow in the next cycle.
// a last coin is folded in the same way, then the row shifts toward cell
// zero one entry a cycle while an accumulator adds the upper entries up to
// entry n; the emit state then loads the result into the output register
// and clears the row. in_coin is not ready during drain and emit.
// the result is then offered on out_result from the output register.
// a result waiting in the output register does not block new coins; if the
// next set finishes while the receiver still stalls, the block holds before
// the clear until the output register is free.
// reset clears the row to a certain zero-head entry and leaves no result
// pending.
module majority_heads_probability_top (
  input logic      clk,
  input logic      rst_n,
  mhp_in_if.sink   in_coin,
  mhp_out_if.source out_result
);
  import mhp_pkg::*;

  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  coin_count_r, coin_count_nxt;
  logic                overflow_r, overflow_nxt;
  logic [COUNT_W-1:0]  idx_r, idx_nxt;
  logic [DIST_W-1:0]   acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_tail_r, out_tail_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_flag_r, out_flag_nxt;

  cell_cmd_t           cmd;
  logic [DIST_W-1:0]   head_val;
  logic                in_fire;
  logic                out_free;
  logic                room;
  logic                drain_end;
  logic [PROB_W-1:0]   prob_sat;
  logic [COUNT_W:0]    half_cnt;
  logic [DIST_W:0]     sum;

  assign in_fire   = in_coin.valid && in_coin.ready;
  assign out_free  = !out_valid_r || out_result.ready;
  assign room      = coin_count_r < COUNT_MAX;
  assign drain_end = idx_r == coin_count_r;
  assign prob_sat  = (in_coin.coin_probability > PROB_ONE) ? PROB_ONE
                                                           : in_coin.coin_probability;
  assign half_cnt  = ({1'b0, coin_count_r} + (COUNT_W + 1)'(1)) >> 1;
  assign sum       = {1'b0, acc_r} + {1'b0, head_val};

  mhp_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .head_val (head_val)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN:   if (in_fire && in_coin.last_coin) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_end) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    in_coin.ready = 1'b0;
    cmd.op        = CELL_HOLD;
    cmd.prob      = prob_sat;
    case (state_r)
      ST_RUN: begin
        in_coin.ready = 1'b1;
        if (in_fire && room) cmd.op = CELL_UPDATE;
      end
      ST_DRAIN: cmd.op = CELL_SHIFT;
      ST_EMIT:  if (out_free) cmd.op = CELL_CLEAR;
      default:  cmd.op = CELL_HOLD;
    endcase
  end

  always_comb begin
    coin_count_nxt = coin_count_r;
    overflow_nxt   = overflow_r;
    idx_nxt        = idx_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r && !out_result.ready;
    out_tail_nxt   = out_tail_r;
    out_count_nxt  = out_count_r;
    out_flag_nxt   = out_flag_r;
    case (state_r)
      ST_RUN: begin
        if (in_fire) begin
          if (room) begin
            coin_count_nxt = coin_count_r + COUNT_W'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
          idx_nxt = '0;
          acc_nxt = '0;
        end
      end
      ST_DRAIN: begin
        idx_nxt = idx_r + COUNT_W'(1);
        if ({1'b0, idx_r} >= half_cnt) begin
          acc_nxt = (sum > {1'b0, DIST_ONE}) ? DIST_ONE : sum[DIST_W-1:0];
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_tail_nxt   = acc_r;
          out_count_nxt  = coin_count_r;
          out_flag_nxt   = overflow_r;
          coin_count_nxt = '0;
          overflow_nxt   = 1'b0;
        end
      end
      default: begin
        coin_count_nxt = coin_count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      coin_count_r <= '0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      coin_count_r <= coin_count_nxt;
      overflow_r   <= overflow_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    out_tail_r  <= out_tail_nxt;
    out_count_r <= out_count_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign out_result.valid            = out_valid_r;
  assign out_result.tail_probability = out_tail_r;
  assign out_result.coins_seen       = OUT_COUNT_W'(out_count_r);
  assign out_result.too_many_coins   = out_flag_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    coin_count_r <= COUNT_MAX)
    else $error("coin count beyond capacity");

  a_drain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |=> $stable(coin_count_r) && $stable(overflow_r))
    else $error("coin state changed during drain");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result raised outside emit");

  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_tail_r <= DIST_ONE)
    else $error("tail probability above one");

endmodule

[hdl/mhp_cell.sv]
`timescale 1ns / 1ps
module mhp_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mhp_pkg::cell_cmd_t         cmd,
  input  logic [mhp_pkg::DIST_W-1:0] below_val,
  input  logic [mhp_pkg::DIST_W-1:0] above_val,
  input  logic [mhp_pkg::DIST_W-1:0] clear_val,
  output logic [mhp_pkg::DIST_W-1:0] val
);
  import mhp_pkg::*;

  logic [DIST_W-1:0]       val_r;
  logic [DIST_W-1:0]       val_nxt;
  logic [DIST_W-1:0]       mixed;
  logic signed [DIST_W:0]  diff;
  logic signed [MIX_W-1:0] prod;
  logic signed [MIX_W-1:0] acc;

  // stay*(1-p) + step*p == stay + (step - stay)*p
  always_comb begin
    diff  = $signed({1'b0, below_val}) - $signed({1'b0, val_r});
    prod  = diff * $signed({1'b0, cmd.prob});
    acc   = prod + $signed(MIX_W'({val_r, {PROB_FRAC{1'b0}}})) + MIX_HALF;
    mixed = acc[PROB_FRAC +: DIST_W];
  end

  always_comb begin
    case (cmd.op)
      CELL_UPDATE: val_nxt = mixed;
      CELL_SHIFT:  val_nxt = above_val;
      CELL_CLEAR:  val_nxt = clear_val;
      default:     val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= clear_val;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

[hdl/mhp_chain.sv]
`timescale 1ns / 1ps
module mhp_chain (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mhp_pkg::cell_cmd_t         cmd,
  output logic [mhp_pkg::DIST_W-1:0] head_val
);
  import mhp_pkg::*;

  logic [DIST_W-1:0] vals [NUM_CELLS];

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    logic [DIST_W-1:0] below;
    logic [DIST_W-1:0] above;
    logic [DIST_W-1:0] init;

    if (g == 0) begin : g_base
      assign below = '0;
      assign init  = DIST_ONE;
    end else begin : g_mid
      assign below = vals[g-1];
      assign init  = '0;
    end

    if (g == NUM_CELLS - 1) begin : g_end
      assign above = '0;
    end else begin : g_next
      assign above = vals[g+1];
    end

    mhp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .below_val (below),
      .above_val (above),
      .clear_val (init),
      .val       (vals[g])
    );
  end

  assign head_val = vals[0];

endmodule
